// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, idle while rst_n is low.
`define SDSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on clk that also runs during reset.
`define SDSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sdsa_pkg.sv =====
`default_nettype none

package sdsa_pkg;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int NODE_IDX_W = 10;
    localparam int TERM_W     = 32;
    localparam int ACC_W      = 48;
    localparam int DAMP_W     = 32;
    localparam int PROD_W     = TERM_W + DAMP_W;
    localparam int FRAC_W     = 16;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPRING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Input payload, node_a in the low bits
    typedef struct packed {
        logic [3:0]            pad;
        logic [DAMP_W-1:0]     damp_y;
        logic [DAMP_W-1:0]     damp_x;
        logic [ACC_W-1:0]      start_accel_y;
        logic [ACC_W-1:0]      start_accel_x;
        logic [TERM_W-1:0]     node_term;
        logic [NODE_IDX_W-1:0] node_b;
        logic [NODE_IDX_W-1:0] node_a;
    } in_word_t;

    // Output payload, node_echo in the low bits
    typedef struct packed {
        logic [5:0]            pad;
        logic [ACC_W-1:0]      accel_y_out;
        logic [ACC_W-1:0]      accel_x_out;
        logic [NODE_IDX_W-1:0] node_echo;
    } out_word_t;

    localparam int IN_DATA_W  = $bits(in_word_t);
    localparam int OUT_DATA_W = $bits(out_word_t);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // 48-bit signed add, clamped to the 48-bit range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spring_damping_scatter_add.sv =====
// Per-node damping scatter-add.
// Input stream (s_axis): tuser carries the kind, tdata the payload. A load word
// writes a node's term and starting x/y accelerations; a spring word adds
// damp_x*term and damp_y*term (Q16.16 products, low 16 bits dropped) into the
// saturated 48-bit x/y accumulators of both end nodes, node_a first; a read
// word returns one node's accumulators on the output stream (m_axis).
// Only read words produce an output word; unused kinds are dropped.
// The term and accumulator memories are single-port, so words are taken one
// at a time: each spring end is a read, a multiply stage and an add/write-back,
// with node_b read while node_a is in its multiply stage and the node_a result
// forwarded when both ends match. A read result passes through the readout
// register and then the output register before it appears on m_axis.
// The output register holds one result; the block keeps taking words while it
// waits, and a second read stalls in its ST_RD state until m_axis_tready.
// Reset clears the control state only; node memories are undefined until a
// load writes them. Indexes at or above NODE_COUNT are ignored by loads and
// springs, and read back as zero.
`default_nettype none

module spring_damping_scatter_add
    import sdsa_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // node_a, node_b, node_term, start_accel_x, start_accel_y, damp_x, damp_y, pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // node_echo, accel_x_out, accel_y_out, pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

`include "assert_macros.svh"

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EXT_W  = NODE_IDX_W + ADDR_W;
    localparam int CMP_W  = NODE_IDX_W + 18;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_A_MUL = 3'd2;
    localparam logic [2:0] ST_A_ADD = 3'd3;
    localparam logic [2:0] ST_B_MUL = 3'd4;
    localparam logic [2:0] ST_B_ADD = 3'd5;

    // Node memories
    logic [TERM_W-1:0]  term_mem [NODE_COUNT];
    logic [2*ACC_W-1:0] acc_mem  [NODE_COUNT];

    in_word_t           in_word;
    logic [2:0]         state_reg, state_next;
    in_word_t           item_reg;
    logic               a_ok_reg, b_ok_reg, same_reg;
    logic [TERM_W-1:0]  rd_term_reg;
    logic [2*ACC_W-1:0] rd_acc_reg;
    logic [2*ACC_W-1:0] acc_a_reg;
    logic [ACC_W-1:0]   prod_x_reg, prod_y_reg;
    logic [ACC_W-1:0]   wb_x_reg, wb_y_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic               accept, out_load;
    logic               in_a_ok, in_b_ok;
    logic [NODE_IDX_W-1:0] addr_idx;
    logic [EXT_W-1:0]   addr_ext;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_re, term_we, acc_we;
    logic [2*ACC_W-1:0] acc_wdata;
    logic [PROD_W-1:0]  full_x, full_y;
    logic [ACC_W-1:0]   base_x, base_y, sum_x, sum_y;
    out_word_t          out_next;

    assign in_word       = in_word_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_a_ok       = CMP_W'(in_word.node_a) < CMP_W'(NODE_COUNT);
    assign in_b_ok       = CMP_W'(in_word.node_b) < CMP_W'(NODE_COUNT);

    // Single memory address per cycle
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  addr_idx = in_word.node_a;
            ST_A_MUL: addr_idx = item_reg.node_b;
            ST_B_MUL: addr_idx = item_reg.node_b;
            ST_B_ADD: addr_idx = item_reg.node_b;
            default:  addr_idx = item_reg.node_a;
        endcase
    end
    assign addr_ext = {{ADDR_W{1'b0}}, addr_idx};
    assign mem_addr = addr_ext[ADDR_W-1:0];

    // Memory enables
    assign mem_re  = (accept && (s_axis_tuser == KIND_SPRING || s_axis_tuser == KIND_READ))
                     || (state_reg == ST_A_MUL);
    assign term_we = accept && (s_axis_tuser == KIND_LOAD) && in_a_ok;
    assign acc_we  = term_we || (state_reg == ST_A_ADD && a_ok_reg)
                     || (state_reg == ST_B_ADD && b_ok_reg);

    // Products of the coefficient and the end's term, Q32.32
    assign full_x = PROD_W'($signed(item_reg.damp_x) * $signed(rd_term_reg));
    assign full_y = PROD_W'($signed(item_reg.damp_y) * $signed(rd_term_reg));

    // Accumulate; node_a uses its held readout, node_b equal to node_a takes
    // the value just written
    assign base_x = (state_reg == ST_A_ADD) ? acc_a_reg[ACC_W-1:0] :
                    (state_reg == ST_B_ADD && same_reg) ? wb_x_reg : rd_acc_reg[ACC_W-1:0];
    assign base_y = (state_reg == ST_A_ADD) ? acc_a_reg[2*ACC_W-1:ACC_W] :
                    (state_reg == ST_B_ADD && same_reg) ? wb_y_reg
                                                        : rd_acc_reg[2*ACC_W-1:ACC_W];
    assign sum_x  = sat_add(base_x, prod_x_reg);
    assign sum_y  = sat_add(base_y, prod_y_reg);

    assign acc_wdata = (state_reg == ST_IDLE) ? {in_word.start_accel_y, in_word.start_accel_x}
                                              : {sum_y, sum_x};

    always_ff @(posedge clk)
    begin
        if (term_we)
            term_mem[mem_addr] <= in_word.node_term;
        if (acc_we)
            acc_mem[mem_addr] <= acc_wdata;
        if (mem_re)
        begin
            rd_term_reg <= term_mem[mem_addr];
            rd_acc_reg  <= acc_mem[mem_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tuser == KIND_SPRING)
                    state_next = ST_A_MUL;
                else if (accept && s_axis_tuser == KIND_READ)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_A_MUL: state_next = ST_A_ADD;
            ST_A_ADD: state_next = ST_B_MUL;
            ST_B_MUL: state_next = ST_B_ADD;
            ST_B_ADD: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Read result
    always_comb
    begin
        out_next.pad         = '0;
        out_next.node_echo   = item_reg.node_a;
        out_next.accel_x_out = a_ok_reg ? rd_acc_reg[ACC_W-1:0] : '0;
        out_next.accel_y_out = a_ok_reg ? rd_acc_reg[2*ACC_W-1:ACC_W] : '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
            a_ok_reg <= in_a_ok;
            b_ok_reg <= in_b_ok;
            same_reg <= (in_word.node_a == in_word.node_b);
        end
        // node_a accumulators, kept while node_b is read
        if (state_reg == ST_A_MUL)
            acc_a_reg <= rd_acc_reg;
        if (state_reg == ST_A_MUL || state_reg == ST_B_MUL)
        begin
            prod_x_reg <= full_x[PROD_W-1:FRAC_W];
            prod_y_reg <= full_y[PROD_W-1:FRAC_W];
        end
        if (state_reg == ST_A_ADD)
        begin
            wb_x_reg <= sum_x;
            wb_y_reg <= sum_y;
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_reg);

    // Checks
    `SDSA_ASSERT(a_out_from_read, $rose(m_axis_tvalid) |-> $past(state_reg == ST_RD), "result without read")
    `SDSA_ASSERT(a_spring_seq, (state_reg == ST_A_MUL) |=> (state_reg == ST_A_ADD) ##1 (state_reg == ST_B_MUL), "spring sequence broken")
    `SDSA_ASSERT(a_no_write_in_mul, (state_reg == ST_A_MUL || state_reg == ST_B_MUL) |-> !acc_we && !term_we, "write during multiply")
    `SDSA_ASSERT_ALWAYS(a_busy_not_ready, (state_reg != ST_IDLE) |-> !s_axis_tready, "ready while busy")

endmodule

`default_nettype wire

// ===== bench/tb_spring_damping_scatter_add.sv =====
`default_nettype none

module tb_spring_damping_scatter_add;
    timeunit 1ns;
    timeprecision 1ps;

    import sdsa_pkg::*;

    localparam int NODE_COUNT     = 1024;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int POOL_SIZE      = 24;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    // Kind with no defined operation; the block drops it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Signed 48-bit accumulator range
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 64'sd1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    spring_damping_scatter_add #(
        .NODE_COUNT(NODE_COUNT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Node memory mirror; queues the accumulator readouts still owed
    class damping_predictor;
        int          node_term_q [NODE_COUNT];
        longint      node_acc_x  [NODE_COUNT];
        longint      node_acc_y  [NODE_COUNT];
        out_word_t   pending_readouts [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Q16.16 x Q16.16 -> Q32.16, low bits dropped toward minus infinity
        function longint damped_term(int coeff, int term);
            longint prod;
            prod = longint'(coeff) * longint'(term);
            return prod >>> FRAC_W;
        endfunction

        function longint clamp48(longint sum);
            if (sum > ACC_HI)
                return ACC_HI;
            if (sum < ACC_LO)
                return ACC_LO;
            return sum;
        endfunction

        // One spring end: x first, then y, each clamped separately
        function void damp_end(int node, int coeff_x, int coeff_y);
            if (node >= NODE_COUNT)
                return;
            node_acc_x[node] = clamp48(node_acc_x[node]
                                       + damped_term(coeff_x, node_term_q[node]));
            node_acc_y[node] = clamp48(node_acc_y[node]
                                       + damped_term(coeff_y, node_term_q[node]));
        endfunction

        // Called for every accepted input word, in acceptance order
        function void note_word(logic [KIND_W-1:0] kind, in_word_t w);
            int        a;
            int        b;
            out_word_t readout;
            a = int'(w.node_a);
            b = int'(w.node_b);
            case (kind)
                KIND_LOAD:
                begin
                    if (a < NODE_COUNT)
                    begin
                        node_term_q[a] = int'($signed(w.node_term));
                        node_acc_x[a]  = longint'($signed(w.start_accel_x));
                        node_acc_y[a]  = longint'($signed(w.start_accel_y));
                    end
                end
                KIND_SPRING:
                begin
                    damp_end(a, int'($signed(w.damp_x)), int'($signed(w.damp_y)));
                    damp_end(b, int'($signed(w.damp_x)), int'($signed(w.damp_y)));
                end
                KIND_READ:
                begin
                    readout = '0;
                    readout.node_echo = w.node_a;
                    if (a < NODE_COUNT)
                    begin
                        readout.accel_x_out = node_acc_x[a][ACC_W-1:0];
                        readout.accel_y_out = node_acc_y[a][ACC_W-1:0];
                    end
                    pending_readouts.push_back(readout);
                end
                default:
                begin
                end
            endcase
        endfunction

        // Called for every accepted output word
        function void compare_readout(out_word_t got);
            out_word_t want;
            if (pending_readouts.size() == 0)
            begin
                mismatches++;
                $display("%0t: readout with none expected: node %0d x %h y %h",
                         $time, got.node_echo, got.accel_x_out, got.accel_y_out);
                return;
            end
            want = pending_readouts.pop_front();
            if (got.node_echo !== want.node_echo)
            begin
                mismatches++;
                $display("%0t: node_echo expected %0d actual %0d",
                         $time, want.node_echo, got.node_echo);
            end
            if (got.accel_x_out !== want.accel_x_out)
            begin
                mismatches++;
                $display("%0t: accel_x_out node %0d expected %h actual %h",
                         $time, want.node_echo, want.accel_x_out, got.accel_x_out);
            end
            if (got.accel_y_out !== want.accel_y_out)
            begin
                mismatches++;
                $display("%0t: accel_y_out node %0d expected %h actual %h",
                         $time, want.node_echo, want.accel_y_out, got.accel_y_out);
            end
        endfunction
    endclass

    damping_predictor predictor;

    // Loaded-node bookkeeping: springs and reads only touch loaded nodes
    bit                    is_loaded [NODE_COUNT];
    logic [NODE_IDX_W-1:0] loaded_nodes [$];
    logic [NODE_IDX_W-1:0] node_pool [POOL_SIZE];

    int unsigned burst_left;
    int unsigned idle_cycles = 0;
    int unsigned rx_mode     = 0;
    int unsigned rx_left     = 0;
    int unsigned rx_tick     = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Signed value biased toward the ends of its range, zero, -1 and small magnitudes
    function automatic logic [63:0] pick_value(int unsigned width);
        logic [63:0] v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = (64'd1 << (width - 1)) - 64'd1;
            1: v = 64'd1 << (width - 1);
            2: v = '0;
            3: v = '1;
            4, 5:
            begin
                v = 64'($urandom_range(0, 1 << 18));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Every field random; callers overwrite the ones their kind uses
    function automatic in_word_t noise_word();
        in_word_t    w;
        logic [63:0] v;
        w = '0;
        v = {$urandom, $urandom};
        w.node_a = v[NODE_IDX_W-1:0];
        w.node_b = v[2*NODE_IDX_W-1:NODE_IDX_W];
        w.node_term = $urandom;
        v = pick_value(ACC_W);
        w.start_accel_x = v[ACC_W-1:0];
        v = pick_value(ACC_W);
        w.start_accel_y = v[ACC_W-1:0];
        w.damp_x = $urandom;
        w.damp_y = $urandom;
        return w;
    endfunction

    // Present one word, hold it until accepted, then idle between bursts
    task automatic send_word(input logic [KIND_W-1:0] kind, input in_word_t w);
        int unsigned gap;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predictor.note_word(kind, w);
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic load_node(input logic [NODE_IDX_W-1:0] node,
                             input logic [TERM_W-1:0] term,
                             input logic [ACC_W-1:0] ax,
                             input logic [ACC_W-1:0] ay);
        in_word_t w;
        w = noise_word();
        w.node_a = node;
        w.node_term = term;
        w.start_accel_x = ax;
        w.start_accel_y = ay;
        if (!is_loaded[node])
        begin
            is_loaded[node] = 1'b1;
            loaded_nodes.push_back(node);
        end
        send_word(KIND_LOAD, w);
    endtask

    task automatic apply_spring(input logic [NODE_IDX_W-1:0] a,
                                input logic [NODE_IDX_W-1:0] b,
                                input logic [DAMP_W-1:0] dx,
                                input logic [DAMP_W-1:0] dy);
        in_word_t w;
        w = noise_word();
        w.node_a = a;
        w.node_b = b;
        w.damp_x = dx;
        w.damp_y = dy;
        send_word(KIND_SPRING, w);
    endtask

    task automatic read_node(input logic [NODE_IDX_W-1:0] node);
        in_word_t w;
        w = noise_word();
        w.node_a = node;
        send_word(KIND_READ, w);
    endtask

    function automatic logic [NODE_IDX_W-1:0] any_loaded();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    // Output side: check each accepted word, stall on a changing pattern
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            predictor.compare_readout(out_word_t'(m_axis_tdata));
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        else
        begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ((rx_tick % 7) < 3);
        endcase
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned           issued;
        int unsigned           sel;
        logic [NODE_IDX_W-1:0] node;
        logic [63:0]           v_term;
        logic [63:0]           v_x;
        logic [63:0]           v_y;

        predictor  = new();
        burst_left = $urandom_range(1, 48);
        node_pool[0] = '0;
        node_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            node_pool[k] = NODE_IDX_W'($urandom);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, saturation both ways, same node at both ends
        load_node(10'd0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_0000, 48'h8000_0000_FFFF);
        load_node(10'd1023, 32'h8000_0000, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF);
        load_node(10'd5, 32'h0001_0000, 48'h0000_0000_0000, 48'h0000_0000_0000);
        read_node(10'd0);
        read_node(10'd1023);
        apply_spring(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
        read_node(10'd0);
        read_node(10'd1023);
        apply_spring(10'd5, 10'd5, 32'hFFFF_FFFF, 32'h0001_8000);
        read_node(10'd5);
        send_word(KIND_UNUSED, noise_word());
        apply_spring(10'd0, 10'd0, 32'h8000_0000, 32'h8000_0000);
        read_node(10'd0);
        load_node(10'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        apply_spring(10'd1023, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        read_node(10'd0);
        read_node(10'd1023);
        apply_spring(10'd5, 10'd1023, 32'h0000_0001, 32'hFFFF_FFFF);
        read_node(10'd5);
        read_node(10'd1023);

        // Random: mostly springs and reads over a small set of loaded nodes
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 22)
            begin
                if ($urandom_range(0, 4) == 0)
                    node = NODE_IDX_W'($urandom);
                else
                    node = node_pool[$urandom_range(0, POOL_SIZE - 1)];
                v_term = pick_value(TERM_W);
                v_x = pick_value(ACC_W);
                v_y = pick_value(ACC_W);
                load_node(node, v_term[TERM_W-1:0], v_x[ACC_W-1:0], v_y[ACC_W-1:0]);
                issued++;
            end
            else if (sel < 62)
            begin
                v_x = pick_value(DAMP_W);
                v_y = pick_value(DAMP_W);
                node = any_loaded();
                if ($urandom_range(0, 9) == 0)
                    apply_spring(node, node, v_x[DAMP_W-1:0], v_y[DAMP_W-1:0]);
                else
                    apply_spring(node, any_loaded(), v_x[DAMP_W-1:0], v_y[DAMP_W-1:0]);
                issued++;
            end
            else if (sel < 95)
            begin
                read_node(any_loaded());
                issued++;
            end
            else
            begin
                send_word(KIND_UNUSED, noise_word());
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding readouts, then a short settle
        while (predictor.pending_readouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predictor.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/sdsa_pkg.sv
rtl/spring_damping_scatter_add.sv
bench/tb_spring_damping_scatter_add.sv
